// ===== hdl/audio_jitter_ring_buffer_assert.svh =====
// Assertion macros used by the checker file.
`ifndef AUDIO_JITTER_RING_BUFFER_ASSERT_SVH
`define AUDIO_JITTER_RING_BUFFER_ASSERT_SVH

// Same-cycle implication, masked while reset is low.
`define AJRB_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ajrb check failed");

// Next-cycle implication, masked while reset is low.
`define AJRB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ajrb check failed");

// Next-cycle implication that also covers the reset cycles.
`define AJRB_ASSERT_NEXT_ANY(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("ajrb check failed");

`endif

// ===== hdl/ajrb_pkg.sv =====
package ajrb_pkg;

  // Defaults for the top-level parameters
  localparam int RING_BYTES_DEF    = 4096;
  localparam int FRAME_SAMPLES_DEF = 32;

  // Fixed field widths
  localparam int CFG_W      = 12;
  localparam int FILL_OUT_W = 12;
  localparam int LEVEL_W    = 21;
  localparam int SAMPLE_W   = 16;

  localparam logic [CFG_W-1:0] PREBUF_RESET = 12'd2048;
  localparam logic [5:0]       LEVEL_GAIN   = 6'd50;

  // Input item codes
  localparam logic [1:0] MODE_WRITE = 2'd0;
  localparam logic [1:0] MODE_PLAY  = 2'd1;
  localparam logic [1:0] MODE_RESET = 2'd2;

  // Result status codes
  typedef enum logic [2:0] {
    ST_STORED   = 3'd0,
    ST_FULL     = 3'd1,
    ST_NO_SPEAK = 3'd2,
    ST_PREBUF   = 3'd3,
    ST_UNDERRUN = 3'd4,
    ST_SAMPLE   = 3'd5,
    ST_ODD_BYTE = 3'd6
  } status_t;

  // Controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_RD_HI,
    S_EMIT
  } state_t;

  // Magnitude of a 16-bit sample times the level gain, kept to 21 bits
  function automatic logic [LEVEL_W-1:0] level_of(input logic [SAMPLE_W-1:0] smp);
    logic [SAMPLE_W:0]   mag;
    logic [SAMPLE_W+6:0] prod;
    mag  = smp[SAMPLE_W-1] ? (17'h10000 - {1'b0, smp}) : {1'b0, smp};
    prod = mag * LEVEL_GAIN;
    return prod[LEVEL_W-1:0];
  endfunction

endpackage

// ===== hdl/ajrb_in_if.sv =====
interface ajrb_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] data_byte;
  logic       speaking;
  logic       flush;

  modport source (output valid, mode, data_byte, speaking, flush, input ready);
  modport sink   (input valid, mode, data_byte, speaking, flush, output ready);
endinterface

// ===== hdl/ajrb_out_if.sv =====
interface ajrb_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         status;
  logic signed [15:0] sample;
  logic               last;
  logic [20:0]        audio_level;
  logic [11:0]        fill_bytes;

  modport source (output valid, status, sample, last, audio_level, fill_bytes, input ready);
  modport sink   (input valid, status, sample, last, audio_level, fill_bytes, output ready);
endinterface

// ===== hdl/ajrb_ring_mem.sv =====
module ajrb_ring_mem #(
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [7:0]               wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [7:0]               rdata
);

  logic [7:0] ring_r [DEPTH];
  logic [7:0] rdata_r;

  // Store one byte
  always_ff @(posedge clk) begin
    if (we) begin
      ring_r[waddr] <= wdata;
    end
  end

  // Read one byte, hold the data until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= ring_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/ajrb_ctrl.sv =====
module ajrb_ctrl #(
  parameter int RING_BYTES    = 4096,
  parameter int FRAME_SAMPLES = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [ajrb_pkg::CFG_W-1:0]    prebuf,
  ajrb_in_if.sink                       in_ch,
  ajrb_out_if.source                    out_ch,
  output logic                          mem_we,
  output logic [$clog2(RING_BYTES)-1:0] mem_waddr,
  output logic [7:0]                    mem_wdata,
  output logic                          mem_re,
  output logic [$clog2(RING_BYTES)-1:0] mem_raddr,
  input  logic [7:0]                    mem_rdata
);
  import ajrb_pkg::*;

  localparam int AW          = $clog2(RING_BYTES);
  localparam int CW          = $clog2(FRAME_SAMPLES + 1);
  localparam int FRAME_BYTES = 2 * FRAME_SAMPLES;
  localparam logic [AW-1:0] LAST_ADDR = AW'(RING_BYTES - 1);

  state_t               state_r, state_nxt;
  logic [AW-1:0]        wp_r, wp_nxt;
  logic [AW-1:0]        rp_r, rp_nxt;
  logic [AW-1:0]        fill_r, fill_nxt;
  logic                 started_r, started_nxt;
  logic [LEVEL_W-1:0]   lvl_r, lvl_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic                 first_r, first_nxt;
  logic [7:0]           lo_r, lo_nxt;

  logic                 out_valid_r;
  status_t              out_status_r;
  logic signed [15:0]   out_sample_r;
  logic                 out_last_r;
  logic [LEVEL_W-1:0]   out_level_r;
  logic [FILL_OUT_W-1:0] out_fill_r;

  logic                 out_free;
  logic                 in_acc;
  logic                 out_load;
  status_t              ld_status;
  logic signed [15:0]   ld_sample;
  logic                 ld_last;
  logic [LEVEL_W-1:0]   ld_level;
  logic [31:0]          fill_wide;
  logic [31:0]          fill_after_wide;
  logic [31:0]          half_wide;
  logic [CW-1:0]        half;
  logic [AW-1:0]        wp_inc;
  logic [AW-1:0]        rp_inc;
  logic [15:0]          smp;
  logic [LEVEL_W-1:0]   smp_level;

  assign out_free  = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE) && out_free;
  assign in_acc    = in_ch.valid && in_ch.ready;

  // Pointer advance with wrap at the ring size
  assign wp_inc = (wp_r == LAST_ADDR) ? '0 : wp_r + 1'b1;
  assign rp_inc = (rp_r == LAST_ADDR) ? '0 : rp_r + 1'b1;

  // Samples in the next frame: fill capped at one frame, halved
  assign fill_wide = 32'(fill_r);
  assign half_wide = ((fill_wide > FRAME_BYTES) ? 32'(FRAME_BYTES) : fill_wide) >> 1;
  assign half      = half_wide[CW-1:0];

  // Assembled little-endian sample and its level
  assign smp       = {mem_rdata, lo_r};
  assign smp_level = level_of(smp);

  assign fill_after_wide = 32'(fill_nxt);

  // Next state, pointers and result selection
  always_comb begin
    state_nxt   = state_r;
    wp_nxt      = wp_r;
    rp_nxt      = rp_r;
    fill_nxt    = fill_r;
    started_nxt = started_r;
    lvl_nxt     = lvl_r;
    cnt_nxt     = cnt_r;
    first_nxt   = first_r;
    lo_nxt      = lo_r;
    mem_we      = 1'b0;
    mem_waddr   = wp_r;
    mem_wdata   = in_ch.data_byte;
    mem_re      = 1'b0;
    mem_raddr   = rp_r;
    out_load    = 1'b0;
    ld_status   = ST_STORED;
    ld_sample   = '0;
    ld_last     = 1'b1;
    ld_level    = lvl_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          unique case (in_ch.mode)
            MODE_WRITE: begin
              out_load = 1'b1;
              if (fill_r >= LAST_ADDR) begin
                ld_status = ST_FULL;
              end else begin
                mem_we    = 1'b1;
                wp_nxt    = wp_inc;
                fill_nxt  = fill_r + 1'b1;
                ld_status = ST_STORED;
              end
            end
            MODE_RESET: begin
              rp_nxt      = wp_r;
              fill_nxt    = '0;
              started_nxt = 1'b0;
            end
            MODE_PLAY: begin
              priority if (!in_ch.speaking) begin
                out_load  = 1'b1;
                ld_status = ST_NO_SPEAK;
              end else if (!started_r && (fill_wide < 32'(prebuf)) && !in_ch.flush) begin
                out_load  = 1'b1;
                ld_status = ST_PREBUF;
              end else if (fill_r == '0) begin
                out_load    = 1'b1;
                ld_status   = ST_UNDERRUN;
                started_nxt = in_ch.flush;
              end else if (half == '0) begin
                out_load    = 1'b1;
                ld_status   = ST_ODD_BYTE;
                started_nxt = 1'b1;
              end else begin
                // Start a frame: fetch the low byte of the first sample
                started_nxt = 1'b1;
                fill_nxt    = fill_r - AW'({half, 1'b0});
                cnt_nxt     = half;
                first_nxt   = 1'b1;
                mem_re      = 1'b1;
                rp_nxt      = rp_inc;
                state_nxt   = S_RD_HI;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_RD_HI: begin
        // Capture the low byte, fetch the high byte
        lo_nxt    = mem_rdata;
        mem_re    = 1'b1;
        rp_nxt    = rp_inc;
        state_nxt = S_EMIT;
      end

      S_EMIT: begin
        if (out_free) begin
          out_load  = 1'b1;
          ld_status = ST_SAMPLE;
          ld_sample = smp;
          ld_last   = (cnt_r == CW'(1));
          if (first_r) begin
            ld_level = smp_level;
            lvl_nxt  = smp_level;
          end
          first_nxt = 1'b0;
          cnt_nxt   = cnt_r - 1'b1;
          if (cnt_r == CW'(1)) begin
            state_nxt = S_IDLE;
          end else begin
            mem_re    = 1'b1;
            rp_nxt    = rp_inc;
            state_nxt = S_RD_HI;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      wp_r      <= '0;
      rp_r      <= '0;
      fill_r    <= '0;
      started_r <= 1'b0;
      lvl_r     <= '0;
      cnt_r     <= '0;
      first_r   <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      wp_r      <= wp_nxt;
      rp_r      <= rp_nxt;
      fill_r    <= fill_nxt;
      started_r <= started_nxt;
      lvl_r     <= lvl_nxt;
      cnt_r     <= cnt_nxt;
      first_r   <= first_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r <= lo_nxt;
  end

  // Result register: load on a new result, drop after transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status_r <= ld_status;
      out_sample_r <= ld_sample;
      out_last_r   <= ld_last;
      out_level_r  <= ld_level;
      out_fill_r   <= fill_after_wide[FILL_OUT_W-1:0];
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.sample      = out_sample_r;
  assign out_ch.last        = out_last_r;
  assign out_ch.audio_level = out_level_r;
  assign out_ch.fill_bytes  = out_fill_r;

endmodule

// ===== hdl/audio_jitter_ring_buffer.sv =====
// Channel  Direction  Transfer when        Payload
// in_ch    in         valid && ready       mode, data_byte, speaking, flush
// out_ch   out        valid && ready       status, sample, last, audio_level, fill_bytes
// cfg      in         cfg_we high          cfg_wdata -> prebuffer_bytes
//
// Write and status-only items load their result into the output register on the
// next cycle; a reset item is taken without a result.
// A frame starts by reading the first low byte; each sample then needs a low and a
// high byte read: the ring memory has one read port and delivers one byte per cycle.
// Reset clears pointers, fill, playout flag and level; ring contents are kept.
// A stalled output holds the frame and blocks new input items.
module audio_jitter_ring_buffer #(
  parameter int RING_BYTES    = ajrb_pkg::RING_BYTES_DEF,
  parameter int FRAME_SAMPLES = ajrb_pkg::FRAME_SAMPLES_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  ajrb_in_if.sink                    in_ch,
  ajrb_out_if.source                 out_ch,
  input  logic                       cfg_we,
  input  logic [ajrb_pkg::CFG_W-1:0] cfg_wdata
);
  import ajrb_pkg::*;

  localparam int AW = $clog2(RING_BYTES);

  logic [CFG_W-1:0] prebuf_r;
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [7:0]       mem_wdata;
  logic             mem_re;
  logic [AW-1:0]    mem_raddr;
  logic [7:0]       mem_rdata;

  // Hold the prebuffer threshold
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prebuf_r <= PREBUF_RESET;
    end else if (cfg_we) begin
      prebuf_r <= cfg_wdata;
    end
  end

  ajrb_ctrl #(
    .RING_BYTES    (RING_BYTES),
    .FRAME_SAMPLES (FRAME_SAMPLES)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .prebuf    (prebuf_r),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  ajrb_ring_mem #(
    .DEPTH (RING_BYTES)
  ) u_ring_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

// ===== hdl/ajrb_checker.sv =====
`include "audio_jitter_ring_buffer_assert.svh"

module ajrb_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_status,
  input logic [15:0] out_sample,
  input logic        out_last
);
  import ajrb_pkg::*;

  // A stalled result keeps its sample
  `AJRB_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_sample))

  // Every result other than a sample is single, with a zero sample
  `AJRB_ASSERT_NOW(a_status_single, out_valid && (out_status != ST_SAMPLE), (out_sample == 16'd0) && out_last)

  // No new item is taken while a frame is still being played
  `AJRB_ASSERT_NOW(a_frame_blocks, out_valid && (out_status == ST_SAMPLE) && !out_last, !in_ready)

  // Reset empties the result register
  `AJRB_ASSERT_NEXT_ANY(a_reset_empty, !rst_n, !out_valid)

endmodule

bind audio_jitter_ring_buffer ajrb_checker u_ajrb_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_status (out_ch.status),
  .out_sample (out_ch.sample),
  .out_last   (out_ch.last)
);
